FILE: sv/wio_pkg.sv
// Shared constants, register and item codes, and the sinc kernel for the wavetable oscillator.
`timescale 1ns / 1ps

package wio_pkg;

    // Default sizes
    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Phase fixed point and filter shape
    localparam int FRAC_BITS = 24;
    localparam int STEP_WHOLE_W = 10;
    localparam int TAP_COUNT = 19;
    localparam int TAP_CENTER = (TAP_COUNT - 1) / 2;
    localparam int TAP_CNT_W = $clog2(TAP_COUNT);
    localparam int TAP_SHIFT = 12;
    localparam int COEF_BITS = 16;
    localparam int COEF_W = COEF_BITS + 1;
    localparam int OUT_SHIFT = FRAC_BITS - TAP_SHIFT + COEF_BITS;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = FRAC_BITS;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_WHOLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_FRACTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANTIALIAS_ON  = 2'd2;

    // Item kinds carried on tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Windowed-sinc kernel, Q.16
    function automatic logic signed [COEF_W-1:0] sinc_coef(input logic [TAP_CNT_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        unique case (tap)
            5'd0:    c = 17'sd69;
            5'd1:    c = 17'sd280;
            5'd2:    c = 17'sd232;
            5'd3:    c = -17'sd954;
            5'd4:    c = -17'sd3139;
            5'd5:    c = -17'sd3329;
            5'd6:    c = 17'sd3067;
            5'd7:    c = 17'sd17109;
            5'd8:    c = 17'sd32537;
            5'd9:    c = 17'sd39325;
            5'd10:   c = 17'sd32537;
            5'd11:   c = 17'sd17109;
            5'd12:   c = 17'sd3067;
            5'd13:   c = -17'sd3329;
            5'd14:   c = -17'sd3139;
            5'd15:   c = -17'sd954;
            5'd16:   c = 17'sd232;
            5'd17:   c = 17'sd280;
            5'd18:   c = 17'sd69;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/wio_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wio_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/wavetable_interp_oscillator.sv
// Top level of the wavetable oscillator: table RAM, phase, sequencer and shared multiplier.
// Load item: written to the table on accept, no result. Tick item, plain mode: steps RD0, RD1,
// RD2, MULI, TAP, FIN. Tick item, antialias mode: 19 taps, each through RD0, RD1, RD2, MULI,
// TAP, MULC and ACC, then FIN; the single table read port and the one shared multiplier serve all taps.
// A new item is taken once the previous tick has placed its result in the output register.
// Reset clears phase and sequencer and loads step 1.0, plain mode; table contents stay unknown.
`timescale 1ns / 1ps

module wavetable_interp_oscillator #(
    parameter int TABLE_SIZE  = wio_pkg::TABLE_SIZE_DEF,
    parameter int SAMPLE_BITS = wio_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W = $clog2(TABLE_SIZE),
    localparam int IN_DATA_W = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [wio_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wio_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,   // table_index, table_value, zero pad
    input  logic                            s_tuser,   // mode
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata    // sample_out, zero pad
);

    localparam int FRAC_BITS = wio_pkg::FRAC_BITS;
    localparam int POS_W = IDX_W + FRAC_BITS;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int INTERP_W = SAMPLE_BITS + 26;
    localparam int TAP_W = INTERP_W - wio_pkg::TAP_SHIFT;
    localparam int MUL_B_W = FRAC_BITS + 1;
    localparam int PROD_W = TAP_W + MUL_B_W;
    localparam int ACC_W = PROD_W + 5;
    localparam int RES_W = ACC_W - wio_pkg::OUT_SHIFT;
    localparam int STEP_FULL_W = wio_pkg::STEP_WHOLE_W + FRAC_BITS;

    localparam logic signed [INTERP_W-1:0] RND_TAP = INTERP_W'(1) <<< (wio_pkg::TAP_SHIFT - 1);
    localparam logic signed [INTERP_W-1:0] RND_PLAIN = INTERP_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_OUT = ACC_W'(1) <<< (wio_pkg::OUT_SHIFT - 1);
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RD0  = 9'b000000010,
        ST_RD1  = 9'b000000100,
        ST_RD2  = 9'b000001000,
        ST_MULI = 9'b000010000,
        ST_TAP  = 9'b000100000,
        ST_MULC = 9'b001000000,
        ST_ACC  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    // Control and configuration registers
    state_t                                state_reg, state_next;
    logic [wio_pkg::TAP_CNT_W-1:0]         tap_cnt_reg, tap_cnt_next;
    logic [POS_W-1:0]                      pos_reg, pos_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [wio_pkg::STEP_WHOLE_W-1:0]      step_whole_reg, step_whole_next;
    logic [FRAC_BITS-1:0]                  step_fraction_reg, step_fraction_next;
    logic                                  antialias_reg, antialias_next;

    // Datapath registers
    logic [POS_W-1:0]                      p_reg, p_next;
    logic signed [SAMPLE_BITS-1:0]         s0_reg, s0_next;
    logic signed [DIFF_W-1:0]              diff_reg, diff_next;
    logic signed [PROD_W-1:0]              prod_reg, prod_next;
    logic signed [INTERP_W-1:0]            interp_reg, interp_next;
    logic signed [TAP_W-1:0]               tap_reg, tap_next;
    logic signed [ACC_W-1:0]               acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0]                out_data_reg, out_data_next;

    // Combinational signals
    logic                                  in_accept;
    logic                                  load_we;
    logic [IDX_W-1:0]                      in_index;
    logic [SAMPLE_BITS-1:0]                in_value;
    logic [POS_W-1:0]                      step;
    logic [POS_W-1:0]                      half;
    logic [POS_W-1:0]                      span;
    logic [IDX_W-1:0]                      p_idx;
    logic [IDX_W-1:0]                      rd_addr;
    logic [SAMPLE_BITS-1:0]                rd_data;
    logic signed [TAP_W-1:0]               mul_a;
    logic signed [MUL_B_W-1:0]             mul_b;
    logic signed [PROD_W-1:0]              mul_prod;
    logic signed [INTERP_W-1:0]            interp_sum;
    logic signed [INTERP_W-1:0]            tap_rnd;
    logic signed [INTERP_W-1:0]            plain_rnd;
    logic signed [ACC_W-1:0]               out_rnd;
    logic signed [RES_W-1:0]               res_val;
    logic signed [RES_W-1:0]               res_sat;
    logic                                  last_tap;
    logic                                  out_free;

    // Unpack input item
    assign in_index  = s_tdata[IDX_W-1:0];
    assign in_value  = s_tdata[IDX_W+SAMPLE_BITS-1:IDX_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign load_we   = in_accept && (s_tuser == wio_pkg::MODE_LOAD);

    // Step, half step and the offset back to the first tap
    assign step = POS_W'(STEP_FULL_W'({step_whole_reg, step_fraction_reg}));
    assign half = step >> 1;
    assign span = POS_W'(half * POS_W'(wio_pkg::TAP_CENTER));
    assign p_idx = p_reg[POS_W-1:FRAC_BITS];

    // Read the entry at the phase, then its neighbor (wraps to entry 0)
    assign rd_addr = (state_reg == ST_RD1) ? IDX_W'(p_idx + IDX_W'(1)) : p_idx;

    wio_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (in_index),
        .wr_data (in_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared multiplier: slope times fraction, or tap times kernel coefficient
    always_comb
    begin
        if (state_reg == ST_MULC)
        begin
            mul_a = tap_reg;
            mul_b = MUL_B_W'(wio_pkg::sinc_coef(tap_cnt_reg));
        end
        else
        begin
            mul_a = TAP_W'(diff_reg);
            mul_b = $signed({1'b0, p_reg[FRAC_BITS-1:0]});
        end
    end
    assign mul_prod = mul_a * mul_b;

    // Interpolation and rounding
    assign interp_sum = (INTERP_W'(s0_reg) <<< FRAC_BITS) + $signed(prod_reg[INTERP_W-1:0]);
    assign tap_rnd    = interp_sum + RND_TAP;
    assign plain_rnd  = interp_reg + RND_PLAIN;
    assign out_rnd    = acc_reg + RND_OUT;

    // Pick the rounded result and saturate it
    always_comb
    begin
        if (antialias_reg)
        begin
            res_val = $signed(out_rnd[ACC_W-1:wio_pkg::OUT_SHIFT]);
        end
        else
        begin
            res_val = RES_W'($signed(plain_rnd[INTERP_W-1:FRAC_BITS]));
        end
        priority if (res_val > SAT_HI)
        begin
            res_sat = SAT_HI;
        end
        else if (res_val < SAT_LO)
        begin
            res_sat = SAT_LO;
        end
        else
        begin
            res_sat = res_val;
        end
    end

    assign last_tap = (tap_cnt_reg == wio_pkg::TAP_CNT_W'(wio_pkg::TAP_COUNT - 1));
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer and next-state values
    always_comb
    begin
        state_next         = state_reg;
        tap_cnt_next       = tap_cnt_reg;
        pos_next           = pos_reg;
        out_valid_next     = out_valid_reg;
        step_whole_next    = step_whole_reg;
        step_fraction_next = step_fraction_reg;
        antialias_next     = antialias_reg;
        p_next             = p_reg;
        s0_next            = s0_reg;
        diff_next          = diff_reg;
        prod_next          = prod_reg;
        interp_next        = interp_reg;
        tap_next           = tap_reg;
        acc_next           = acc_reg;
        out_data_next      = out_data_reg;

        // Drop the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wio_pkg::CFG_STEP_WHOLE:
                begin
                    step_whole_next = cfg_data[wio_pkg::STEP_WHOLE_W-1:0];
                end
                wio_pkg::CFG_STEP_FRACTION:
                begin
                    step_fraction_next = cfg_data[FRAC_BITS-1:0];
                end
                wio_pkg::CFG_ANTIALIAS_ON:
                begin
                    antialias_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == wio_pkg::MODE_TICK))
                begin
                    p_next       = antialias_reg ? POS_W'(pos_reg - span) : pos_reg;
                    acc_next     = '0;
                    tap_cnt_next = '0;
                    state_next   = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                s0_next    = $signed(rd_data);
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                diff_next  = DIFF_W'($signed(rd_data)) - DIFF_W'(s0_reg);
                state_next = ST_MULI;
            end
            ST_MULI:
            begin
                prod_next  = mul_prod;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                interp_next = interp_sum;
                tap_next    = $signed(tap_rnd[INTERP_W-1:wio_pkg::TAP_SHIFT]);
                state_next  = antialias_reg ? ST_MULC : ST_FIN;
            end
            ST_MULC:
            begin
                prod_next  = mul_prod;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // Accumulate and advance to the next tap position
                acc_next = acc_reg + ACC_W'(prod_reg);
                p_next   = POS_W'(p_reg + half);
                if (last_tap)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    tap_cnt_next = tap_cnt_reg + wio_pkg::TAP_CNT_W'(1);
                    state_next   = ST_RD0;
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free, then post and advance phase
                if (out_free)
                begin
                    out_data_next  = res_sat[SAMPLE_BITS-1:0];
                    out_valid_next = 1'b1;
                    pos_next       = POS_W'(pos_reg + step);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            tap_cnt_reg       <= '0;
            pos_reg           <= '0;
            out_valid_reg     <= 1'b0;
            step_whole_reg    <= wio_pkg::STEP_WHOLE_W'(1);
            step_fraction_reg <= '0;
            antialias_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tap_cnt_reg       <= tap_cnt_next;
            pos_reg           <= pos_next;
            out_valid_reg     <= out_valid_next;
            step_whole_reg    <= step_whole_next;
            step_fraction_reg <= step_fraction_next;
            antialias_reg     <= antialias_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        s0_reg       <= s0_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        interp_reg   <= interp_next;
        tap_reg      <= tap_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule
